>>> design/assert_macros.svh
// Assertion macros shared by the RRT extend block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define RNSE_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication
`define RNSE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/rnse_pkg.sv
// Types, constants and codes shared by the RRT extend block
package rnse_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int COORD_BITS_DEF = 16;

    localparam int STEP_W    = 15;              // step_length and goal_radius width
    localparam int IDX_OUT_W = 10;              // reported index width
    localparam int Q_W       = STEP_W;          // scaled step quotient width
    localparam int QBW       = $clog2(Q_W);     // quotient bit pointer width
    localparam int CFG_IDX_W = 3;

    localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(256);
    localparam logic [STEP_W-1:0] RADIUS_RST = STEP_W'(128);

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_EXTEND  = 2'd0,
        ACT_REJECT  = 2'd1,
        ACT_RESTART = 2'd2
    } act_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP   = 3'd0,
        REG_RADIUS = 3'd1,
        REG_GOAL_X = 3'd2,
        REG_GOAL_Y = 3'd3,
        REG_GOAL_Z = 3'd4,
        REG_ROOT_X = 3'd5,
        REG_ROOT_Y = 3'd6,
        REG_ROOT_Z = 3'd7
    } cfg_reg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SDRAIN,
        ST_NRD,
        ST_NCAP,
        ST_MSQ,
        ST_TGT,
        ST_CAND,
        ST_TEST,
        ST_NEXT,
        ST_WRITE,
        ST_GOAL,
        ST_GWAIT,
        ST_EMIT,
        ST_RJCAP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic           cap;      // capture sample fields
        logic           rd_en;    // node store read
        logic           srch;     // read belongs to the nearest search
        logic           ncap;     // capture nearest node and direction
        logic           msq;      // square one direction component, clear quotient
        logic           tgt;      // form quotient target
        logic           cand;     // form trial value for one quotient bit
        logic           test;     // keep or drop that bit
        logic           store;    // finish one coordinate of the new point
        logic           wr;       // write new point to the store
        logic           ld_mem;   // new point from the store read
        logic           ld_root;  // new point from the root registers
        logic           goal;     // start the goal distance test
        logic           emit;     // load the result register
        logic           full;     // result reports a full store
        logic [1:0]     ax;       // axis in work
        logic [QBW-1:0] bitn;     // quotient bit in work
    } cmd_t;

endpackage

>>> design/rnse_ctrl.sv
// Sequencer for the RRT extend block: search, steer, rewrite and result hand-off
`include "assert_macros.svh"

module rnse_ctrl #(
    parameter int MAX_NODES = rnse_pkg::MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [1:0]                   s_action,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output rnse_pkg::cmd_t               cmd,
    output logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic [$clog2(MAX_NODES)-1:0] wr_addr,
    output logic [$clog2(MAX_NODES)-1:0] out_idx,
    output logic [$clog2(MAX_NODES)-1:0] out_par,
    input  logic [$clog2(MAX_NODES)-1:0] near_idx
);
    import rnse_pkg::*;

    localparam int AW  = $clog2(MAX_NODES);
    localparam int CNW = $clog2(MAX_NODES + 1);
    localparam logic [CNW-1:0] CNT_MAX = CNW'(MAX_NODES);

    state_t         state_reg, state_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     wt_reg, wt_next;
    logic [1:0]     ax_reg, ax_next;
    logic [QBW-1:0] bit_reg, bit_next;
    logic [CNW-1:0] count_reg, count_next;
    logic [AW-1:0]  lp_reg, lp_next;
    logic [AW-1:0]  wa_reg, wa_next;
    logic [AW-1:0]  oidx_reg, oidx_next;
    logic [AW-1:0]  opar_reg, opar_next;
    logic           wrf_reg, wrf_next;
    logic           full_reg, full_next;
    logic           mv_reg, mv_next;

    logic [AW-1:0]  last_k;
    logic [AW-1:0]  rj_par;

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            wt_reg    <= '0;
            ax_reg    <= '0;
            bit_reg   <= '0;
            count_reg <= CNW'(1);
            lp_reg    <= '0;
            wa_reg    <= '0;
            oidx_reg  <= '0;
            opar_reg  <= '0;
            wrf_reg   <= 1'b0;
            full_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wt_reg    <= wt_next;
            ax_reg    <= ax_next;
            bit_reg   <= bit_next;
            count_reg <= count_next;
            lp_reg    <= lp_next;
            wa_reg    <= wa_next;
            oidx_reg  <= oidx_next;
            opar_reg  <= opar_next;
            wrf_reg   <= wrf_next;
            full_reg  <= full_next;
            mv_reg    <= mv_next;
        end
    end

    // Reject target: last node and its parent
    assign last_k = AW'(count_reg - CNW'(1));
    assign rj_par = (lp_reg < last_k) ? lp_reg : '0;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wt_next    = wt_reg;
        ax_next    = ax_reg;
        bit_next   = bit_reg;
        count_next = count_reg;
        lp_next    = lp_reg;
        wa_next    = wa_reg;
        oidx_next  = oidx_reg;
        opar_next  = opar_reg;
        wrf_next   = wrf_reg;
        full_next  = full_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        cmd.ax     = ax_reg;
        cmd.bitn   = bit_reg;
        cmd.full   = full_reg;
        rd_addr    = cnt_reg;
        s_tready   = 1'b0;

        // result register drains independently of the sequencer
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap   = 1'b1;
                    full_next = 1'b0;
                    case (act_t'(s_action))
                        ACT_EXTEND: begin
                            if (count_reg == CNT_MAX) begin
                                full_next  = 1'b1;
                                oidx_next  = '0;
                                opar_next  = '0;
                                state_next = ST_EMIT;
                            end else begin
                                cnt_next   = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        ACT_REJECT: begin
                            cmd.rd_en = 1'b1;
                            if (count_reg <= CNW'(1)) begin
                                rd_addr   = '0;
                                wrf_next  = 1'b0;
                                oidx_next = '0;
                                opar_next = '0;
                            end else begin
                                rd_addr   = rj_par;
                                wrf_next  = 1'b1;
                                wa_next   = last_k;
                                oidx_next = last_k;
                                opar_next = rj_par;
                            end
                            state_next = ST_RJCAP;
                        end
                        ACT_RESTART: begin
                            cmd.ld_root = 1'b1;
                            count_next  = CNW'(1);
                            lp_next     = '0;
                            wa_next     = '0;
                            oidx_next   = '0;
                            opar_next   = '0;
                            state_next  = ST_WRITE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // one stored node read per cycle
            ST_SEARCH: begin
                cmd.rd_en = 1'b1;
                cmd.srch  = 1'b1;
                rd_addr   = cnt_reg;
                if (CNW'(cnt_reg) == count_reg - CNW'(1)) begin
                    wt_next    = '0;
                    state_next = ST_SDRAIN;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            // let the distance pipeline empty
            ST_SDRAIN: begin
                wt_next = wt_reg + 2'd1;
                if (wt_reg == 2'd2) begin
                    state_next = ST_NRD;
                end
            end
            ST_NRD: begin
                cmd.rd_en  = 1'b1;
                rd_addr    = near_idx;
                state_next = ST_NCAP;
            end
            ST_NCAP: begin
                cmd.ncap   = 1'b1;
                ax_next    = '0;
                state_next = ST_MSQ;
            end
            ST_MSQ: begin
                cmd.msq    = 1'b1;
                state_next = ST_TGT;
            end
            ST_TGT: begin
                cmd.tgt    = 1'b1;
                bit_next   = QBW'(Q_W - 1);
                state_next = ST_CAND;
            end
            ST_CAND: begin
                cmd.cand   = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.test = 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_NEXT;
                end else begin
                    bit_next   = bit_reg - QBW'(1);
                    state_next = ST_CAND;
                end
            end
            ST_NEXT: begin
                cmd.store = 1'b1;
                if (ax_reg == 2'd2) begin
                    wa_next    = AW'(count_reg);
                    oidx_next  = AW'(count_reg);
                    opar_next  = near_idx;
                    lp_next    = near_idx;
                    count_next = count_reg + CNW'(1);
                    state_next = ST_WRITE;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_MSQ;
                end
            end
            ST_RJCAP: begin
                cmd.ld_mem = 1'b1;
                state_next = wrf_reg ? ST_WRITE : ST_GOAL;
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_GOAL;
            end
            ST_GOAL: begin
                cmd.goal   = 1'b1;
                wt_next    = '0;
                state_next = ST_GWAIT;
            end
            ST_GWAIT: begin
                wt_next = wt_reg + 2'd1;
                if (wt_reg == 2'd1) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!mv_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mv_reg;
    assign wr_addr  = wa_reg;
    assign out_idx  = oidx_reg;
    assign out_par  = opar_reg;

    `RNSE_CHECK(a_count_range, (count_reg >= CNW'(1)) && (count_reg <= CNT_MAX), "node count out of range")
    `RNSE_IMPLY(a_full_emit, cmd.emit && full_reg, count_reg == CNT_MAX, "full flag without full store")
    `RNSE_IMPLY(a_search_addr, state_reg == ST_SEARCH, CNW'(cnt_reg) < count_reg, "search past last node")

endmodule

>>> design/rnse_dp.sv
// Datapath of the RRT extend block: node store, distance pipeline, bit-serial step scaler
`include "assert_macros.svh"

module rnse_dp #(
    parameter int MAX_NODES  = rnse_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = rnse_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr,
    input  logic [rnse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((COORD_BITS > rnse_pkg::STEP_W) ? COORD_BITS : rnse_pkg::STEP_W)-1:0]
                                         cfg_data,
    input  logic [3*COORD_BITS-1:0]      s_data,
    input  rnse_pkg::cmd_t               cmd,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [$clog2(MAX_NODES)-1:0] out_idx,
    input  logic [$clog2(MAX_NODES)-1:0] out_par,
    output logic [$clog2(MAX_NODES)-1:0] near_idx,
    output logic [((3*COORD_BITS + 2*rnse_pkg::IDX_OUT_W + 1 + 7) / 8) * 8 - 1:0] m_data,
    output logic                         m_full
);
    import rnse_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int AW   = $clog2(MAX_NODES);
    localparam int SQW  = 2 * C;
    localparam int SUMW = 2 * C + 2;
    localparam int TW   = 2 * C + 2 * STEP_W;
    localparam int PW   = 2 * C + 2 + 2 * Q_W;
    localparam int QSW  = 2 * C + 2 + Q_W;
    localparam int GW   = (SUMW > 2 * STEP_W) ? SUMW : 2 * STEP_W;
    localparam int EW   = ((C > STEP_W) ? C : STEP_W) + 2;
    localparam int TDW  = ((3 * C + 2 * IDX_OUT_W + 1 + 7) / 8) * 8;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    // configuration
    logic [STEP_W-1:0]      step_reg, rad_reg;
    logic signed [C-1:0]    goal_reg [3];
    logic signed [C-1:0]    root_reg [3];
    logic [2*STEP_W-1:0]    st2_reg, r2_reg;

    // store and read port
    logic [3*C-1:0]         mem [MAX_NODES];
    logic [3*C-1:0]         rdata_reg;
    logic                   rz_reg, root_valid_reg;
    logic signed [C-1:0]    rpt [3];

    // distance pipeline
    logic                   sv0_reg, sv1_reg, sv2_reg, gv1_reg, gv2_reg;
    logic [AW-1:0]          idx0_reg, idx1_reg, idx2_reg;
    logic signed [C-1:0]    pa [3];
    logic signed [C-1:0]    pb [3];
    logic signed [C:0]      pd [3];
    logic [C-1:0]           pm [3];
    logic [SQW-1:0]         sq_reg [3];
    logic [SUMW-1:0]        sum_reg, best_reg;
    logic [AW-1:0]          near_reg;
    logic                   hit_reg;

    // steering
    logic signed [C-1:0]    sample_reg [3];
    logic signed [C-1:0]    base_reg [3];
    logic [C-1:0]           mag_reg [3];
    logic                   neg_reg [3];
    logic signed [C:0]      nd [3];
    logic [SQW-1:0]         msq_reg;
    logic [TW-1:0]          tgt_reg;
    logic [PW-1:0]          p_reg, cand_reg;
    logic [QSW-1:0]         qs_reg;
    logic [Q_W-1:0]         q_reg;
    logic signed [C-1:0]    newp_reg [3];
    logic [Q_W-1:0]         qoff;
    logic signed [EW-1:0]   soff, ssum;
    logic signed [C-1:0]    ssat;

    logic [TDW-1:0]         tdata_reg;
    logic                   tuser_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RST;
            rad_reg  <= RADIUS_RST;
            for (int i = 0; i < 3; i++) begin
                goal_reg[i] <= '0;
                root_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP:   step_reg    <= cfg_data[STEP_W-1:0];
                REG_RADIUS: rad_reg     <= cfg_data[STEP_W-1:0];
                REG_GOAL_X: goal_reg[0] <= cfg_data[C-1:0];
                REG_GOAL_Y: goal_reg[1] <= cfg_data[C-1:0];
                REG_GOAL_Z: goal_reg[2] <= cfg_data[C-1:0];
                REG_ROOT_X: root_reg[0] <= cfg_data[C-1:0];
                REG_ROOT_Y: root_reg[1] <= cfg_data[C-1:0];
                REG_ROOT_Z: root_reg[2] <= cfg_data[C-1:0];
                default: ;
            endcase
        end
    end

    // Squared step and radius, held ready
    always_ff @(posedge aclk) begin
        st2_reg <= step_reg * step_reg;
        r2_reg  <= rad_reg * rad_reg;
    end

    // Node store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[wr_addr] <= {newp_reg[2], newp_reg[1], newp_reg[0]};
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        rz_reg <= !root_valid_reg && (rd_addr == '0);
    end

    // entry 0 holds the zero root until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_valid_reg <= 1'b0;
        end else if (cmd.wr && wr_addr == '0) begin
            root_valid_reg <= 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rpt[i] = rz_reg ? '0 : rdata_reg[i*C +: C];
        end
    end

    // Sample capture
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            for (int i = 0; i < 3; i++) begin
                sample_reg[i] <= s_data[i*C +: C];
            end
        end
    end

    // Pipeline tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv0_reg <= 1'b0;
            sv1_reg <= 1'b0;
            sv2_reg <= 1'b0;
            gv1_reg <= 1'b0;
            gv2_reg <= 1'b0;
        end else begin
            sv0_reg <= cmd.srch;
            sv1_reg <= sv0_reg;
            sv2_reg <= sv1_reg;
            gv1_reg <= cmd.goal;
            gv2_reg <= gv1_reg;
        end
    end

    // Stage 1 operands: stored node against sample, or new point against goal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa[i] = cmd.goal ? newp_reg[i] : rpt[i];
            pb[i] = cmd.goal ? goal_reg[i] : sample_reg[i];
            pd[i] = $signed({pa[i][C-1], pa[i]}) - $signed({pb[i][C-1], pb[i]});
            pm[i] = pd[i][C] ? C'(-pd[i]) : C'(pd[i]);
        end
    end

    // Squares, sum, then compare
    always_ff @(posedge aclk) begin
        idx0_reg <= rd_addr;
        idx1_reg <= idx0_reg;
        idx2_reg <= idx1_reg;
        for (int i = 0; i < 3; i++) begin
            sq_reg[i] <= pm[i] * pm[i];
        end
        sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        if (sv2_reg && (idx2_reg == '0 || sum_reg < best_reg)) begin
            best_reg <= sum_reg;
            near_reg <= idx2_reg;
        end
        if (gv2_reg) begin
            hit_reg <= GW'(sum_reg) < GW'(r2_reg);
        end
    end

    assign near_idx = near_reg;

    // Direction from the nearest node
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nd[i] = $signed({sample_reg[i][C-1], sample_reg[i]}) - $signed({rpt[i][C-1], rpt[i]});
        end
    end

    // Final coordinate: signed offset, added and saturated
    always_comb begin
        qoff = (mag_reg[cmd.ax] == '0) ? '0 : q_reg;
        soff = neg_reg[cmd.ax] ? -$signed(EW'(qoff)) : $signed(EW'(qoff));
        ssum = EW'(base_reg[cmd.ax]) + soff;
        if (ssum > SAT_HI) begin
            ssat = C'(SAT_HI);
        end else if (ssum < SAT_LO) begin
            ssat = C'(SAT_LO);
        end else begin
            ssat = C'(ssum);
        end
    end

    // Step scaler: largest q with q*q*S <= m*m*st*st, one bit at a time: form a trial value, then keep or drop the bit
    always_ff @(posedge aclk) begin
        if (cmd.ncap) begin
            for (int i = 0; i < 3; i++) begin
                base_reg[i] <= rpt[i];
                neg_reg[i]  <= nd[i][C];
                mag_reg[i]  <= nd[i][C] ? C'(-nd[i]) : C'(nd[i]);
            end
        end
        if (cmd.msq) begin
            msq_reg <= mag_reg[cmd.ax] * mag_reg[cmd.ax];
            p_reg   <= '0;
            qs_reg  <= '0;
            q_reg   <= '0;
        end
        if (cmd.tgt) begin
            tgt_reg <= TW'(msq_reg) * TW'(st2_reg);
        end
        if (cmd.cand) begin
            cand_reg <= p_reg + (PW'(qs_reg) << (cmd.bitn + 1))
                      + (PW'(best_reg) << (2 * cmd.bitn));
        end
        if (cmd.test && cand_reg <= PW'(tgt_reg)) begin
            p_reg          <= cand_reg;
            qs_reg         <= qs_reg + (QSW'(best_reg) << cmd.bitn);
            q_reg[cmd.bitn] <= 1'b1;
        end
    end

    // New point
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            newp_reg[cmd.ax] <= ssat;
        end else if (cmd.ld_mem) begin
            for (int i = 0; i < 3; i++) begin
                newp_reg[i] <= rpt[i];
            end
        end else if (cmd.ld_root) begin
            for (int i = 0; i < 3; i++) begin
                newp_reg[i] <= root_reg[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (cmd.full) begin
                tdata_reg <= '0;
            end else begin
                tdata_reg <= TDW'({hit_reg, IDX_OUT_W'(out_par), IDX_OUT_W'(out_idx),
                                   newp_reg[2], newp_reg[1], newp_reg[0]});
            end
            tuser_reg <= cmd.full;
        end
    end

    assign m_data = tdata_reg;
    assign m_full = tuser_reg;

    `RNSE_IMPLY(a_q_bound, cmd.store && mag_reg[cmd.ax] != '0, q_reg <= step_reg, "step exceeds step length")
    `RNSE_CHECK(a_tag_excl, !(sv2_reg && gv2_reg), "search and goal test overlap")

endmodule

>>> design/rrt_nearest_steer_extend_3d.sv
// RRT extend step in 3D: nearest-node search, steering and node append over a node store.
// One item is taken at a time. For an extend item, the nearest search reads one stored node
// per cycle from the single-read node store, then each of the three offsets is scaled by a
// bit-serial quotient unit over 15 bits.
// The next item is accepted while a finished result still waits in the output register.
// The store needs no clearing pass after reset.
module rrt_nearest_steer_extend_3d #(
    parameter int MAX_NODES  = rnse_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = rnse_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rnse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((COORD_BITS > rnse_pkg::STEP_W) ? COORD_BITS : rnse_pkg::STEP_W)-1:0]
                                           cfg_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_x, sample_y, sample_z
    input  logic [((3*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [1:0]                     s_tuser,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // node_x, node_y, node_z, node_index, parent_index, goal_reached
    output logic [((3*COORD_BITS + 2*rnse_pkg::IDX_OUT_W + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    // store_full
    output logic                           m_tuser
);
    import rnse_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    cmd_t          cmd;
    logic [AW-1:0] rd_addr, wr_addr, out_idx, out_par, near_idx;

    assign cfg_ready = 1'b1;

    rnse_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .out_idx  (out_idx),
        .out_par  (out_par),
        .near_idx (near_idx)
    );

    rnse_dp #(
        .MAX_NODES  (MAX_NODES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_tdata[3*COORD_BITS-1:0]),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .out_idx   (out_idx),
        .out_par   (out_par),
        .near_idx  (near_idx),
        .m_data    (m_tdata),
        .m_full    (m_tuser)
    );

endmodule
